[rtl/core/imu_window_feature_extractor_defines.svh]
// assertion helpers for the imu window feature extractor
`ifndef IMU_WINDOW_FEATURE_EXTRACTOR_DEFINES_SVH
`define IMU_WINDOW_FEATURE_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define IMUWFE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define IMUWFE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMUWFE_ASSERT(name, clk, rst_n, prop, msg)
`define IMUWFE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[rtl/core/imuwfe_pkg.sv]
package imuwfe_pkg;

  // window counter saturates at 2**COUNT_BITS
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int SUM_W      = 16 + COUNT_BITS;
  localparam int SQ_W       = 31 + COUNT_BITS;
  localparam int Q_W        = 31;
  localparam int STEP_W     = $clog2(Q_W);
  localparam int CMP_W      = (CNT_W > 16) ? CNT_W : 16;
  localparam int NUM_AXES   = 3;

  localparam logic [CNT_W-1:0] COUNT_SAT = {1'b1, {COUNT_BITS{1'b0}}};

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic [1:0] axis;
  } acc_ctrl_t;

endpackage

[rtl/core/imu_window_feature_extractor.sv]
// imu window feature extractor
// input channel: one three-axis sample per transfer (in_valid / in_stall),
//   in_last_sample marks the final sample of a window
// result channel: one result per window (out_valid / out_stall) holding
//   count, per-axis means, per-axis mean squares and the largest step
// config: cfg_wr_en writes cfg_wr_data into max_samples; write only when idle
// timing: an ordinary sample takes 4 cycles (accept plus one per axis through
//   the shared squarer and accumulator), in_stall is high meanwhile
// a closing sample takes about 6 + 6 x 33 cycles: six divisions (three means,
//   three mean squares) run one after another on one radix-2 divider that
//   yields one quotient bit per cycle over 31 steps
// an over-long window skips the divisions and reports status 1, zero fields
// the finished result sits in an output register; the next window's samples
//   are accepted while it waits, and the next result waits for it to go
// reset (rst_n low, synchronous) clears all sums, the count, the output
//   register and sets max_samples to 65535
// a stalled result holds all fields steady until its transfer
`include "imu_window_feature_extractor_defines.svh"

module imu_window_feature_extractor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [15:0]        out_window_len,
  output logic signed [15:0] out_mean_x,
  output logic signed [15:0] out_mean_y,
  output logic signed [15:0] out_mean_z,
  output logic [30:0]        out_mean_square_x,
  output logic [30:0]        out_mean_square_y,
  output logic [30:0]        out_mean_square_z,
  output logic [15:0]        out_peak_step,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);
  import imuwfe_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ACC      = 3'd1;
  localparam logic [2:0] ST_CHECK    = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        kind_r, kind_nxt;     // 0 mean pass, 1 mean square pass
  logic        bad_r, bad_nxt;
  logic [15:0] max_samples_r;
  sample_t     sample_r;

  logic signed [15:0] mean_r [NUM_AXES];
  logic [Q_W-1:0]     msq_r  [NUM_AXES];

  // output register
  logic               out_valid_r;
  logic               out_status_r;
  logic [15:0]        out_count_r;
  logic signed [15:0] out_mean_r [NUM_AXES];
  logic [30:0]        out_msq_r  [NUM_AXES];
  logic [15:0]        out_delta_r;

  acc_ctrl_t               acc_ctrl;
  logic signed [SUM_W-1:0] sel_sum;
  logic [SQ_W-1:0]         sel_sq;
  logic [CNT_W-1:0]        count;
  logic [15:0]             largest_delta;

  logic                  div_start;
  logic                  div_done;
  logic [Q_W-1:0]        quotient;
  logic [SQ_W-1:0]       dividend;
  logic [SUM_W-1:0]      sum_mag;
  logic                  in_xfer;
  logic                  out_xfer;
  logic                  load_out;
  logic                  window_ok;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // result register may be refilled once the old result leaves
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign window_ok = (count != COUNT_SAT) &&
                     (CMP_W'(count) <= CMP_W'(max_samples_r));

  assign acc_ctrl.step  = (state_r == ST_ACC);
  assign acc_ctrl.clear = load_out;
  assign acc_ctrl.axis  = axis_r;

  // means divide the magnitude and fix the sign afterwards
  assign sum_mag   = sel_sum[SUM_W-1] ? $unsigned(-sel_sum) : $unsigned(sel_sum);
  assign dividend  = kind_r ? sel_sq : SQ_W'(sum_mag);
  assign div_start = (state_r == ST_DIV_GO);

  imuwfe_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (acc_ctrl),
    .sample        (sample_r),
    .sel_sum       (sel_sum),
    .sel_sq        (sel_sq),
    .count         (count),
    .largest_delta (largest_delta)
  );

  imuwfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (count[COUNT_BITS-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    kind_nxt  = kind_r;
    bad_nxt   = bad_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_ACC;
          axis_nxt  = AXIS_X;
        end
      end
      ST_ACC: begin
        if (axis_r == AXIS_Z) begin
          axis_nxt  = AXIS_X;
          state_nxt = sample_r.last ? ST_CHECK : ST_IDLE;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      ST_CHECK: begin
        // count has settled here, decide before any division
        bad_nxt   = !window_ok;
        kind_nxt  = 1'b0;
        axis_nxt  = AXIS_X;
        state_nxt = window_ok ? ST_DIV_GO : ST_DONE;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (axis_r == AXIS_Z) begin
            axis_nxt  = AXIS_X;
            kind_nxt  = 1'b1;
            state_nxt = kind_r ? ST_DONE : ST_DIV_GO;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      axis_r        <= AXIS_X;
      kind_r        <= 1'b0;
      bad_r         <= 1'b0;
      max_samples_r <= 16'hFFFF;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      kind_r  <= kind_nxt;
      bad_r   <= bad_nxt;
      if (cfg_wr_en) max_samples_r <= cfg_wr_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_xfer) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r.x    <= in_accel_x;
      sample_r.y    <= in_accel_y;
      sample_r.z    <= in_accel_z;
      sample_r.last <= in_last_sample;
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      if (kind_r) msq_r[axis_r] <= quotient;
      else if (sel_sum[SUM_W-1]) mean_r[axis_r] <= -(16'(quotient));
      else mean_r[axis_r] <= 16'(quotient);
    end
    if (load_out) begin
      out_status_r <= bad_r;
      out_count_r  <= bad_r ? 16'd0 : 16'(count);
      out_delta_r  <= bad_r ? 16'd0 : largest_delta;
      for (int i = 0; i < NUM_AXES; i++) begin
        out_mean_r[i] <= bad_r ? 16'sd0 : mean_r[i];
        // a mean square never exceeds 2**30, so no saturation is reached
        out_msq_r[i]  <= bad_r ? 31'd0 : msq_r[i][30:0];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_window_len    = out_count_r;
  assign out_mean_x        = out_mean_r[0];
  assign out_mean_y        = out_mean_r[1];
  assign out_mean_z        = out_mean_r[2];
  assign out_mean_square_x = out_msq_r[0];
  assign out_mean_square_y = out_msq_r[1];
  assign out_mean_square_z = out_msq_r[2];
  assign out_peak_step     = out_delta_r;

  // a result only appears out of the done state
  `IMUWFE_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result without finished window")
  // the accumulator is never stepped while a sample can be taken
  `IMUWFE_ASSERT_ALWAYS(a_step_blocks_input, clk, acc_ctrl.step |-> in_stall, "input open during accumulation")
  // an invalid result carries zero fields
  `IMUWFE_ASSERT(a_bad_zero, clk, rst_n, (out_valid && out_status) |-> (out_window_len == 16'd0 && out_peak_step == 16'd0), "invalid result with data")
  // a valid result covers at least one sample
  `IMUWFE_ASSERT(a_ok_nonempty, clk, rst_n, (out_valid && !out_status) |-> (out_window_len != 16'd0), "valid result with empty window")

endmodule

[rtl/core/imuwfe_div.sv]
module imuwfe_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [imuwfe_pkg::SQ_W-1:0]     dividend,
  input  logic [imuwfe_pkg::COUNT_BITS-1:0] divisor,
  output logic                            done,
  output logic [imuwfe_pkg::Q_W-1:0]      quotient
);
  import imuwfe_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dsr_r, dsr_nxt;
  logic [Q_W-1:0]        dvd_r, dvd_nxt;
  logic [Q_W-1:0]        quo_r, quo_nxt;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;

  // restoring division, one quotient bit per cycle; the quotient is known
  // to fit in Q_W bits so the upper dividend bits seed the remainder
  assign trial = {rem_r, dvd_r[Q_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = !diff[COUNT_BITS];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(Q_W - 1);
      rem_nxt  = dividend[SQ_W-1:Q_W];
      dsr_nxt  = divisor;
      dvd_nxt  = dividend[Q_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_nxt  = {quo_r[Q_W-2:0], qbit};
      dvd_nxt  = {dvd_r[Q_W-2:0], 1'b0};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/imuwfe_accum.sv]
module imuwfe_accum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  imuwfe_pkg::acc_ctrl_t                ctrl,
  input  imuwfe_pkg::sample_t                  sample,
  output logic signed [imuwfe_pkg::SUM_W-1:0]  sel_sum,
  output logic [imuwfe_pkg::SQ_W-1:0]          sel_sq,
  output logic [imuwfe_pkg::CNT_W-1:0]         count,
  output logic [15:0]                          largest_delta
);
  import imuwfe_pkg::*;

  logic signed [SUM_W-1:0] sum_r  [NUM_AXES];
  logic [SQ_W-1:0]         sq_r   [NUM_AXES];
  logic signed [15:0]      prev_r [NUM_AXES];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [15:0]             ld_r, ld_nxt;

  logic signed [15:0] s_cur;
  logic signed [16:0] diff;
  logic [16:0]        abs_d;
  logic signed [31:0] prod;
  logic               open;

  always_comb begin
    case (ctrl.axis)
      AXIS_X:  s_cur = sample.x;
      AXIS_Y:  s_cur = sample.y;
      default: s_cur = sample.z;
    endcase
  end

  assign open  = (count_r != COUNT_SAT);
  assign diff  = {s_cur[15], s_cur} - {prev_r[ctrl.axis][15], prev_r[ctrl.axis]};
  assign abs_d = diff[16] ? 17'(-diff) : 17'(diff);
  // one squarer, time shared over the three axes
  assign prod  = s_cur * s_cur;

  always_comb begin
    ld_nxt    = ld_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      ld_nxt    = '0;
      count_nxt = '0;
    end else if (ctrl.step) begin
      if (count_r != '0 && abs_d[15:0] > ld_r) ld_nxt = abs_d[15:0];
      if (ctrl.axis == AXIS_Z && open) count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ld_r    <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_r[i]  <= '0;
        sq_r[i]   <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      ld_r    <= ld_nxt;
      if (ctrl.clear) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          sum_r[i]  <= '0;
          sq_r[i]   <= '0;
          prev_r[i] <= '0;
        end
      end else if (ctrl.step) begin
        prev_r[ctrl.axis] <= s_cur;
        if (open) begin
          sum_r[ctrl.axis] <= sum_r[ctrl.axis] + SUM_W'(s_cur);
          sq_r[ctrl.axis]  <= sq_r[ctrl.axis] + SQ_W'($unsigned(prod));
        end
      end
    end
  end

  assign sel_sum       = sum_r[ctrl.axis];
  assign sel_sq        = sq_r[ctrl.axis];
  assign count         = count_r;
  assign largest_delta = ld_r;

endmodule
